[design/tcb_pkg.sv]
// ---------------------------------------------------------------------------
// tcb_pkg
// Shared widths, types and register codes for the triangle coverage block.
// ---------------------------------------------------------------------------
package tcb_pkg;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int EDGE_W  = PROD_W + 1;
	localparam int MAG_W   = EDGE_W - 1;
	localparam int BARY_W  = 24;
	localparam int QBITS   = BARY_W - 1;
	localparam int LANE_LAT = QBITS + 2;
	localparam int THR_W   = 32;
	localparam int BARY_FRAC_DEF = 16;

	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] REG_AREA_THR = 2'd0;
	localparam logic [THR_W-1:0]  THR_RESET    = 32'd1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [EDGE_W-1:0]  edge_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic signed [BARY_W-1:0]  bary_t;

	typedef struct packed {
		logic covered;
		logic degen;
	} side_t;

	typedef struct packed {
		logic  covered;
		logic  degen;
		bary_t u;
		bary_t v;
		bary_t w;
	} res_t;

endpackage

[design/tcb_if.sv]
// ---------------------------------------------------------------------------
// tcb_in_if / tcb_out_if
// Valid/ready channels for sample transactions and coverage results.
// ---------------------------------------------------------------------------
interface tcb_in_if;
	import tcb_pkg::*;
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	coord_t vert_a_x;
	coord_t vert_a_y;
	coord_t vert_b_x;
	coord_t vert_b_y;
	coord_t vert_c_x;
	coord_t vert_c_y;

	modport source (output valid, point_x, point_y, vert_a_x, vert_a_y,
		vert_b_x, vert_b_y, vert_c_x, vert_c_y, input ready);
	modport sink (input valid, point_x, point_y, vert_a_x, vert_a_y,
		vert_b_x, vert_b_y, vert_c_x, vert_c_y, output ready);
endinterface

interface tcb_out_if;
	import tcb_pkg::*;
	logic  valid;
	logic  ready;
	logic  inside_res;
	logic  degenerate;
	bary_t bary_u;
	bary_t bary_v;
	bary_t bary_w;

	modport source (output valid, inside_res, degenerate, bary_u, bary_v, bary_w,
		input ready);
	modport sink (input valid, inside_res, degenerate, bary_u, bary_v, bary_w,
		output ready);
endinterface

[design/triangle_coverage_barycentric.sv]
// ---------------------------------------------------------------------------
// triangle_coverage_barycentric
// Edge-function coverage test with top-left rule and barycentric weights.
// ---------------------------------------------------------------------------
// Usage:
//   sample : one transaction per sample point, carrying the point and the
//            three vertices in signed fixed point.
//   result : one transaction per sample: inside flag, degenerate flag and the
//            three saturated weights u, v, w.
//   APB    : register 0 (byte address 0) holds area_threshold; reads return it.
// Throughput is one transaction per cycle unless the receiver stalls. An
// accepted sample reaches the result channel through four stages
// of edge arithmetic (differences, products, edge values, magnitude and
// coverage), then 25 stages of divider (setup, 23 quotient bits, sign and
// saturation), then the output register. The divider's one bit per stage
// sets that depth.
// Reset clears all valid bits and loads area_threshold with 1.
// When the receiver stalls, a skid register catches the one result still
// emerging; the pipeline then freezes and sample.ready drops until the skid
// register drains. No transaction is lost or repeated.
// ---------------------------------------------------------------------------
module triangle_coverage_barycentric #(
	parameter int BARY_FRAC_BITS = tcb_pkg::BARY_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tcb_in_if.sink                      sample,
	tcb_out_if.source                   result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcb_pkg::CFG_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import tcb_pkg::*;

	// configuration register
	logic [THR_W-1:0] thr_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && paddr == REG_AREA_THR) begin
			thr_q <= pwdata;
		end
	end

	assign prdata = (paddr == REG_AREA_THR) ? thr_q : '0;

	// global advance: hold every pipeline stage only while the skid register is full
	logic skid_vld_q;
	logic en;

	assign en = !skid_vld_q;
	assign sample.ready = en;

	// edge functions: index 0 is the area (A,B,C), 1..3 are e0 (B,C,P),
	// e1 (C,A,P) and e2 (A,B,P). E = (p.x-a.x)*(b.y-a.y) - (p.y-a.y)*(b.x-a.x)
	coord_t fax [0:3];
	coord_t fay [0:3];
	coord_t fbx [0:3];
	coord_t fby [0:3];
	coord_t fpx [0:3];
	coord_t fpy [0:3];
	logic [2:0] tl;

	always_comb begin
		fax[0] = sample.vert_a_x; fay[0] = sample.vert_a_y;
		fbx[0] = sample.vert_b_x; fby[0] = sample.vert_b_y;
		fpx[0] = sample.vert_c_x; fpy[0] = sample.vert_c_y;
		fax[1] = sample.vert_b_x; fay[1] = sample.vert_b_y;
		fbx[1] = sample.vert_c_x; fby[1] = sample.vert_c_y;
		fpx[1] = sample.point_x;  fpy[1] = sample.point_y;
		fax[2] = sample.vert_c_x; fay[2] = sample.vert_c_y;
		fbx[2] = sample.vert_a_x; fby[2] = sample.vert_a_y;
		fpx[2] = sample.point_x;  fpy[2] = sample.point_y;
		fax[3] = sample.vert_a_x; fay[3] = sample.vert_a_y;
		fbx[3] = sample.vert_b_x; fby[3] = sample.vert_b_y;
		fpx[3] = sample.point_x;  fpy[3] = sample.point_y;
		// top-left: flat edge running leftwards, or first vertex higher up
		for (int i = 0; i < 3; i++) begin
			tl[i] = (fay[i+1] == fby[i+1] && fax[i+1] > fbx[i+1]) ||
				(fay[i+1] < fby[i+1]);
		end
	end

	// stage 1: differences
	diff_t      dpx_s1 [0:3];
	diff_t      dby_s1 [0:3];
	diff_t      dpy_s1 [0:3];
	diff_t      dbx_s1 [0:3];
	logic [2:0] tl_s1;
	logic       vld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int f = 0; f < 4; f++) begin
				dpx_s1[f] <= DIFF_W'(fpx[f]) - DIFF_W'(fax[f]);
				dby_s1[f] <= DIFF_W'(fby[f]) - DIFF_W'(fay[f]);
				dpy_s1[f] <= DIFF_W'(fpy[f]) - DIFF_W'(fay[f]);
				dbx_s1[f] <= DIFF_W'(fbx[f]) - DIFF_W'(fax[f]);
			end
			tl_s1 <= tl;
		end
	end

	// stage 2: products
	prod_t      p1_s2 [0:3];
	prod_t      p2_s2 [0:3];
	logic [2:0] tl_s2;
	logic       vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int f = 0; f < 4; f++) begin
				p1_s2[f] <= PROD_W'(dpx_s1[f]) * PROD_W'(dby_s1[f]);
				p2_s2[f] <= PROD_W'(dpy_s1[f]) * PROD_W'(dbx_s1[f]);
			end
			tl_s2 <= tl_s1;
		end
	end

	// stage 3: exact edge values
	edge_t      ev_s3 [0:3];
	logic [2:0] tl_s3;
	logic       vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int f = 0; f < 4; f++) begin
				ev_s3[f] <= EDGE_W'(p1_s2[f]) - EDGE_W'(p2_s2[f]);
			end
			tl_s3 <= tl_s2;
		end
	end

	// stage 4: area magnitude, degenerate test and coverage on exact values
	mag_t       amag;
	logic [2:0] cov;

	always_comb begin
		amag = ev_s3[0][EDGE_W-1] ? MAG_W'(-ev_s3[0]) : MAG_W'(ev_s3[0]);
		for (int i = 0; i < 3; i++) begin
			if (ev_s3[i+1] == '0)
				cov[i] = tl_s3[i];
			else
				cov[i] = ev_s3[i+1][EDGE_W-1] == ev_s3[0][EDGE_W-1];
		end
	end

	edge_t ev_s4 [0:2];
	mag_t  amag_s4;
	logic  aneg_s4;
	side_t side_s4;
	logic  vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ev_s4[i] <= ev_s3[i+1];
			end
			amag_s4        <= amag;
			aneg_s4        <= ev_s3[0][EDGE_W-1];
			side_s4.degen   <= (amag == '0) || (amag < MAG_W'(thr_q));
			side_s4.covered <= &cov;
		end
	end

	// divider lanes
	bary_t wgt [0:2];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		tcb_div_lane #(
			.BARY_FRAC_BITS(BARY_FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.en   (en),
			.e    (ev_s4[i]),
			.d    (amag_s4),
			.a_neg(aneg_s4),
			.w    (wgt[i])
		);
	end

	// side band travelling alongside the divider
	side_t side_l [0:LANE_LAT-1];
	logic  vld_l  [0:LANE_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			side_l[0] <= side_s4;
			for (int s = 1; s < LANE_LAT; s++) begin
				side_l[s] <= side_l[s-1];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			for (int s = 0; s < LANE_LAT; s++) begin
				vld_l[s] <= 1'b0;
			end
		end else if (en) begin
			vld_s1   <= sample.valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_l[0] <= vld_s4;
			for (int s = 1; s < LANE_LAT; s++) begin
				vld_l[s] <= vld_l[s-1];
			end
		end
	end

	// pipeline end: drop weights and clear the inside flag of degenerate triangles
	res_t  fin;
	side_t fin_side;

	always_comb begin
		fin_side    = side_l[LANE_LAT-1];
		fin.degen   = fin_side.degen;
		fin.covered = fin_side.covered && !fin_side.degen;
		fin.u       = fin_side.degen ? '0 : wgt[0];
		fin.v       = fin_side.degen ? '0 : wgt[1];
		fin.w       = fin_side.degen ? '0 : wgt[2];
	end

	// output register and skid register
	res_t out_q;
	res_t skid_q;
	logic out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !result.ready) begin
			if (en && vld_l[LANE_LAT-1])
				skid_vld_q <= 1'b1;
		end else if (skid_vld_q) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= vld_l[LANE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !result.ready) begin
			if (en)
				skid_q <= fin;
		end else if (skid_vld_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= fin;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.inside_res = out_q.covered;
	assign result.degenerate = out_q.degen;
	assign result.bary_u     = out_q.u;
	assign result.bary_v     = out_q.v;
	assign result.bary_w     = out_q.w;

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register full while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !result.ready))
		else $error("skid register filled without a stall");

	a_degen_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.degen) |->
		(!out_q.covered && out_q.u == '0 && out_q.v == '0 && out_q.w == '0))
		else $error("degenerate result carries coverage or weights");
`endif

endmodule

[design/tcb_div_lane.sv]
// ---------------------------------------------------------------------------
// tcb_div_lane
// Pipelined restoring divider: one weight, one quotient bit per stage.
// ---------------------------------------------------------------------------
module tcb_div_lane #(
	parameter int BARY_FRAC_BITS = tcb_pkg::BARY_FRAC_DEF
) (
	input  logic          clk,
	input  logic          en,
	input  tcb_pkg::edge_t e,
	input  tcb_pkg::mag_t  d,
	input  logic          a_neg,
	output tcb_pkg::bary_t w
);
	import tcb_pkg::*;

	localparam int SH = QBITS - BARY_FRAC_BITS;
	localparam int NUM_W = MAG_W + BARY_FRAC_BITS;

	mag_t              emag;
	logic [NUM_W-1:0]  num;
	logic              ovf;

	mag_t              rem_s [0:QBITS];
	mag_t              d_s   [0:QBITS];
	logic [QBITS-1:0]  low_s [0:QBITS];
	logic [QBITS-1:0]  q_s   [0:QBITS];
	logic              ovf_s [0:QBITS];
	logic              neg_s [0:QBITS];
	bary_t             w_q;

	always_comb begin
		emag = e[EDGE_W-1] ? MAG_W'(-e) : MAG_W'(e);
		num  = {emag, {BARY_FRAC_BITS{1'b0}}};
		// quotient would need 2^23 or more
		ovf  = (MAG_W+SH)'(emag) >= {d, {SH{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= MAG_W'(emag >> SH);
			d_s[0]   <= d;
			low_s[0] <= num[QBITS-1:0];
			q_s[0]   <= '0;
			ovf_s[0] <= ovf;
			neg_s[0] <= e[EDGE_W-1] ^ a_neg;
		end
	end

	for (genvar j = 0; j < QBITS; j++) begin : g_step
		localparam int K = QBITS - 1 - j;
		logic [MAG_W:0] t;
		logic           ge;
		logic [MAG_W:0] diff;

		always_comb begin
			t    = {rem_s[j], low_s[j][K]};
			ge   = t >= {1'b0, d_s[j]};
			diff = t - {1'b0, d_s[j]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
				d_s[j+1]   <= d_s[j];
				low_s[j+1] <= low_s[j];
				q_s[j+1]   <= {q_s[j][QBITS-2:0], ge};
				ovf_s[j+1] <= ovf_s[j];
				neg_s[j+1] <= neg_s[j];
			end
		end
	end

	// apply sign and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_s[QBITS])
				w_q <= neg_s[QBITS] ? {1'b1, {QBITS{1'b0}}} : {1'b0, {QBITS{1'b1}}};
			else if (neg_s[QBITS])
				w_q <= -{1'b0, q_s[QBITS]};
			else
				w_q <= {1'b0, q_s[QBITS]};
		end
	end

	assign w = w_q;

endmodule
